>>> hw/rtl/i2c_bit_level_master_assert.svh
// Assertion macros used by the port-level checker of the I2C bit-level master.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define I2CM_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define I2CM_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/i2cm_pkg.sv
// Package with the widths, command codes and defaults of the I2C bit-level master.
package i2cm_pkg;

  localparam int unsigned OpW         = 3;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned WaitW       = 10;
  localparam int unsigned DelayBitsDef = 10;

  typedef enum logic [OpW-1:0] {
    OpNone  = 3'd0,
    OpStart = 3'd1,
    OpStop  = 3'd2,
    OpWrite = 3'd3,
    OpRead  = 3'd4
  } op_e;

endpackage

>>> hw/rtl/i2cm_if.sv
// Channel interfaces of the I2C bit-level master: configuration, command and result.
interface i2cm_cfg_if;
  import i2cm_pkg::*;

  logic             valid;
  logic             ready;
  logic [WaitW-1:0] wait_ticks;

  modport source (output valid, output wait_ticks, input ready);
  modport sink (input valid, input wait_ticks, output ready);
endinterface

interface i2cm_cmd_if;
  import i2cm_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [ByteW-1:0] write_byte;
  logic             send_ack;
  logic             scl_in;
  logic             sda_in;

  modport source (output valid, output op, output write_byte, output send_ack,
                  output scl_in, output sda_in, input ready);
  modport sink (input valid, input op, input write_byte, input send_ack,
                input scl_in, input sda_in, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;

  logic             valid;
  logic             ready;
  logic             scl_drive;
  logic             sda_drive;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] read_byte;
  logic             ack_seen;

  modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                  output done_res, output read_byte, output ack_seen, input ready);
  modport sink (input valid, input scl_drive, input sda_drive, input busy_res,
                input done_res, input read_byte, input ack_seen, output ready);
endinterface

>>> hw/rtl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: command sequencer and result register.
// Each command transaction is one tick of bus timing carrying the sampled SCL and SDA levels
// and an optional command, which is taken only while no command is in progress. The block
// accepts one transaction per clock cycle and returns exactly one result transaction for it
// in the next cycle from an output register; input ready drops only while that register holds
// a result the sink has not taken. Pin actions within a command are spaced wait_ticks ticks
// apart (a zero value counts as one), so the SCL period is set by the configuration register.
// The configuration register is written whenever its channel is valid and is always ready.
module i2c_bit_level_master #(
  parameter int unsigned DELAY_BITS = i2cm_pkg::DelayBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_cfg_if.sink    cfg_i,
  i2cm_cmd_if.sink    cmd_i,
  i2cm_res_if.source  res_o
);
  import i2cm_pkg::*;

  localparam int unsigned ExtW    = (DELAY_BITS > WaitW) ? DELAY_BITS : WaitW;
  localparam int unsigned BitCntW = 4;
  localparam logic [BitCntW-1:0] BitsPerByte = BitCntW'(ByteW);

  typedef enum logic [15:0] {
    PhIdle     = 16'h0001,
    PhSt1      = 16'h0002,
    PhSt2      = 16'h0004,
    PhSt3      = 16'h0008,
    PhStEnd    = 16'h0010,
    PhSp1      = 16'h0020,
    PhSp2      = 16'h0040,
    PhSpEnd    = 16'h0080,
    PhWrLow    = 16'h0100,
    PhWrNext   = 16'h0200,
    PhWrAck    = 16'h0400,
    PhWrEnd    = 16'h0800,
    PhRdCheck  = 16'h1000,
    PhRdNext   = 16'h2000,
    PhRdAckEnd = 16'h4000,
    PhRdEnd    = 16'h8000
  } phase_e;

  typedef struct packed {
    logic             scl_drive;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
    logic             ack_seen;
  } res_t;

  logic [WaitW-1:0]      wait_q, wait_d;
  phase_e                phase_q, phase_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [ByteW-1:0]      shift_q, shift_d;
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  logic                  scl_q, scl_d;
  logic                  sda_q, sda_d;
  logic [ByteW-1:0]      received_q, received_d;
  logic                  ack_level_q, ack_level_d;
  logic                  ack_choice_q, ack_choice_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;

  logic                  accept;
  logic                  done;
  logic [ExtW-1:0]       wait_ext;
  logic [DELAY_BITS-1:0] wait_msk;
  logic [DELAY_BITS-1:0] wait_eff;
  logic [DELAY_BITS-1:0] delay_dec;

  assign cfg_i.ready = 1'b1;
  assign wait_d      = cfg_i.valid ? cfg_i.wait_ticks : wait_q;

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign wait_ext  = ExtW'(wait_q);
  assign wait_msk  = wait_ext[DELAY_BITS-1:0];
  assign wait_eff  = (wait_msk == '0) ? DELAY_BITS'(1) : wait_msk;
  assign delay_dec = delay_q - DELAY_BITS'(1);

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    received_d   = received_q;
    ack_level_d  = ack_level_q;
    ack_choice_d = ack_choice_q;
    done         = 1'b0;
    if (accept) begin
      if (phase_q == PhIdle) begin
        unique case (op_e'(cmd_i.op))
          OpStart: begin
            sda_d   = 1'b1;
            delay_d = wait_eff;
            phase_d = PhSt1;
          end
          OpStop: begin
            sda_d   = 1'b0;
            delay_d = wait_eff;
            phase_d = PhSp1;
          end
          OpWrite: begin
            shift_d   = cmd_i.write_byte;
            bit_cnt_d = '0;
            sda_d     = cmd_i.write_byte[ByteW-1];
            scl_d     = 1'b1;
            delay_d   = wait_eff;
            phase_d   = PhWrLow;
          end
          OpRead: begin
            ack_choice_d = cmd_i.send_ack;
            shift_d      = '0;
            bit_cnt_d    = '0;
            sda_d        = 1'b1;
            scl_d        = 1'b1;
            delay_d      = wait_eff;
            phase_d      = PhRdCheck;
          end
          default: begin
          end
        endcase
      end else begin
        delay_d = delay_dec;
        if (delay_dec == '0) begin
          unique case (phase_q)
            PhSt1: begin
              scl_d   = 1'b1;
              delay_d = wait_eff;
              phase_d = PhSt2;
            end
            PhSt2: begin
              sda_d   = 1'b0;
              delay_d = wait_eff;
              phase_d = PhSt3;
            end
            PhSt3: begin
              scl_d   = 1'b0;
              delay_d = wait_eff;
              phase_d = PhStEnd;
            end
            PhSp1: begin
              scl_d   = 1'b1;
              delay_d = wait_eff;
              phase_d = PhSp2;
            end
            PhSp2: begin
              sda_d   = 1'b1;
              delay_d = wait_eff;
              phase_d = PhSpEnd;
            end
            PhWrLow: begin
              shift_d   = {shift_q[ByteW-2:0], 1'b0};
              bit_cnt_d = bit_cnt_q + BitCntW'(1);
              scl_d     = 1'b0;
              delay_d   = wait_eff;
              phase_d   = PhWrNext;
            end
            PhWrNext: begin
              scl_d   = 1'b1;
              delay_d = wait_eff;
              if (bit_cnt_q < BitsPerByte) begin
                sda_d   = shift_q[ByteW-1];
                phase_d = PhWrLow;
              end else begin
                sda_d   = 1'b1;
                phase_d = PhWrAck;
              end
            end
            PhWrAck: begin
              ack_level_d = cmd_i.sda_in;
              scl_d       = 1'b0;
              delay_d     = wait_eff;
              phase_d     = PhWrEnd;
            end
            PhRdCheck: begin
              delay_d = wait_eff;
              if (!cmd_i.scl_in) begin
                scl_d   = 1'b1;
                phase_d = PhRdCheck;
              end else begin
                shift_d   = {shift_q[ByteW-2:0], cmd_i.sda_in};
                bit_cnt_d = bit_cnt_q + BitCntW'(1);
                scl_d     = 1'b0;
                phase_d   = PhRdNext;
              end
            end
            PhRdNext: begin
              scl_d   = 1'b1;
              delay_d = wait_eff;
              if (bit_cnt_q < BitsPerByte) begin
                phase_d = PhRdCheck;
              end else begin
                sda_d   = !ack_choice_q;
                phase_d = PhRdAckEnd;
              end
            end
            PhRdAckEnd: begin
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              delay_d = wait_eff;
              phase_d = PhRdEnd;
            end
            PhRdEnd: begin
              received_d = shift_q;
              phase_d    = PhIdle;
              done       = 1'b1;
            end
            PhStEnd, PhSpEnd, PhWrEnd: begin
              phase_d = PhIdle;
              done    = 1'b1;
            end
            default: begin
              phase_d = PhIdle;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    res_d.scl_drive = scl_d;
    res_d.sda_drive = sda_d;
    res_d.busy_res  = (phase_d != PhIdle);
    res_d.done_res  = done;
    res_d.read_byte = received_d;
    res_d.ack_seen  = ack_level_d;
  end

  assign out_valid_d = accept || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q       <= WaitW'(1);
      phase_q      <= PhIdle;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      delay_q      <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      received_q   <= '0;
      ack_level_q  <= 1'b0;
      ack_choice_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      wait_q       <= wait_d;
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      delay_q      <= delay_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      received_q   <= received_d;
      ack_level_q  <= ack_level_d;
      ack_choice_q <= ack_choice_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_drive = res_q.scl_drive;
  assign res_o.sda_drive = res_q.sda_drive;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.read_byte = res_q.read_byte;
  assign res_o.ack_seen  = res_q.ack_seen;

endmodule

>>> hw/rtl/i2cm_checker.sv
// Port-level checker for the I2C bit-level master and its bind to the top level.
`include "i2c_bit_level_master_assert.svh"

module i2cm_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cmd_valid_i,
  input logic cmd_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic busy_i,
  input logic done_i
);

  `I2CM_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "Result dropped.")
  `I2CM_ASSERT_NXT(a_res_follows, cmd_valid_i && cmd_ready_i, res_valid_i, "Result missing.")
  `I2CM_ASSERT_IMP(a_ready_empty, !res_valid_i, cmd_ready_i, "Input stalled while empty.")
  `I2CM_ASSERT_IMP(a_done_idle, res_valid_i && done_i, !busy_i, "Done while busy.")

endmodule

bind i2c_bit_level_master i2cm_port_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .busy_i      (res_o.busy_res),
  .done_i      (res_o.done_res)
);

>>> dv/i2cm_checker.sv
// Checker for the I2C bit-level master: predicts every result transaction and compares it.
`timescale 1ns / 100ps

module i2cm_checker #(
  parameter int unsigned DelayBits = i2cm_pkg::DelayBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_cfg_if         cfg_i,
  i2cm_cmd_if         cmd_i,
  i2cm_res_if         res_i,
  output logic        bus_busy_o,
  output int unsigned error_count_o,
  output int unsigned backlog_o
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PhIdle,
    PhStartScl,
    PhStartSda,
    PhStartLow,
    PhStartEnd,
    PhStopScl,
    PhStopSda,
    PhStopEnd,
    PhWrLow,
    PhWrNext,
    PhWrAck,
    PhWrEnd,
    PhRdCheck,
    PhRdNext,
    PhRdAckEnd,
    PhRdEnd
  } bus_phase_e;

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx;
    logic             ack;
  } pin_result_t;

  bus_phase_e           phase;
  logic [3:0]           bit_cnt;
  logic [ByteW-1:0]     shifter;
  logic [ByteW-1:0]     rx_byte;
  logic [DelayBits-1:0] delay_cnt;
  logic                 scl_lvl;
  logic                 sda_lvl;
  logic                 ack_lvl;
  logic                 ack_pick;
  logic [WaitW-1:0]     wait_ticks;
  pin_result_t          expected_pins_q[$];
  int unsigned          mismatches;
  int unsigned          backlog;

  assign bus_busy_o    = (phase != PhIdle);
  assign error_count_o = mismatches;
  assign backlog_o     = backlog;

  task automatic arm_wait(input bus_phase_e nxt);
    logic [DelayBits-1:0] span;
    span = DelayBits'(wait_ticks);
    if (span == '0) begin
      span = DelayBits'(1);
    end
    delay_cnt = span;
    phase     = nxt;
  endtask

  task automatic next_write_bit();
    scl_lvl = 1'b1;
    if (bit_cnt < ByteW) begin
      sda_lvl = shifter[ByteW-1];
      arm_wait(PhWrLow);
    end else begin
      sda_lvl = 1'b1;
      arm_wait(PhWrAck);
    end
  endtask

  task automatic next_read_bit();
    scl_lvl = 1'b1;
    if (bit_cnt < ByteW) begin
      arm_wait(PhRdCheck);
    end else begin
      sda_lvl = ~ack_pick;
      arm_wait(PhRdAckEnd);
    end
  endtask

  task automatic fire_action(input logic scl_in, input logic sda_in, output logic fin);
    fin = 1'b0;
    case (phase)
      PhStartScl: begin
        scl_lvl = 1'b1;
        arm_wait(PhStartSda);
      end
      PhStartSda: begin
        sda_lvl = 1'b0;
        arm_wait(PhStartLow);
      end
      PhStartLow: begin
        scl_lvl = 1'b0;
        arm_wait(PhStartEnd);
      end
      PhStopScl: begin
        scl_lvl = 1'b1;
        arm_wait(PhStopSda);
      end
      PhStopSda: begin
        sda_lvl = 1'b1;
        arm_wait(PhStopEnd);
      end
      PhWrLow: begin
        shifter = shifter << 1;
        bit_cnt = bit_cnt + 1'b1;
        scl_lvl = 1'b0;
        arm_wait(PhWrNext);
      end
      PhWrNext: next_write_bit();
      PhWrAck: begin
        ack_lvl = sda_in;
        scl_lvl = 1'b0;
        arm_wait(PhWrEnd);
      end
      PhRdCheck: begin
        // The slave holds SCL low: keep waiting until it lets go.
        if (!scl_in) begin
          scl_lvl = 1'b1;
          arm_wait(PhRdCheck);
        end else begin
          shifter = {shifter[ByteW-2:0], sda_in};
          bit_cnt = bit_cnt + 1'b1;
          scl_lvl = 1'b0;
          arm_wait(PhRdNext);
        end
      end
      PhRdNext: next_read_bit();
      PhRdAckEnd: begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b1;
        arm_wait(PhRdEnd);
      end
      PhRdEnd: begin
        rx_byte = shifter;
        phase   = PhIdle;
        fin     = 1'b1;
      end
      PhStartEnd, PhStopEnd, PhWrEnd: begin
        phase = PhIdle;
        fin   = 1'b1;
      end
      default: phase = PhIdle;
    endcase
  endtask

  task automatic predict_bus_tick(input logic [OpW-1:0] op, input logic [ByteW-1:0] wbyte,
                                  input logic sack, input logic scl_in, input logic sda_in,
                                  output pin_result_t pins);
    logic fin;
    fin = 1'b0;
    if (phase == PhIdle) begin
      case (op)
        OpStart: begin
          sda_lvl = 1'b1;
          arm_wait(PhStartScl);
        end
        OpStop: begin
          sda_lvl = 1'b0;
          arm_wait(PhStopScl);
        end
        OpWrite: begin
          shifter = wbyte;
          bit_cnt = '0;
          next_write_bit();
        end
        OpRead: begin
          ack_pick = sack;
          shifter  = '0;
          bit_cnt  = '0;
          sda_lvl  = 1'b1;
          next_read_bit();
        end
        default: ;
      endcase
    end else begin
      delay_cnt = delay_cnt - 1'b1;
      if (delay_cnt == '0) begin
        fire_action(scl_in, sda_in, fin);
      end
    end
    pins.scl  = scl_lvl;
    pins.sda  = sda_lvl;
    pins.busy = (phase != PhIdle);
    pins.done = fin;
    pins.rx   = rx_byte;
    pins.ack  = ack_lvl;
  endtask

  task automatic compare_field(input string name, input logic [ByteW-1:0] want,
                               input logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pin_result_t want;
    pin_result_t seen;
    if (!rst_ni) begin
      phase      = PhIdle;
      bit_cnt    = '0;
      shifter    = '0;
      rx_byte    = '0;
      delay_cnt  = '0;
      scl_lvl    = 1'b1;
      sda_lvl    = 1'b1;
      ack_lvl    = 1'b0;
      ack_pick   = 1'b0;
      wait_ticks = WaitW'(1);
      expected_pins_q.delete();
      mismatches = 0;
      backlog    = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen = '{res_i.scl_drive, res_i.sda_drive, res_i.busy_res, res_i.done_res,
                 res_i.read_byte, res_i.ack_seen};
        if (expected_pins_q.size() == 0) begin
          $error("Result transaction arrived with no expectation pending.");
          mismatches++;
        end else begin
          want = expected_pins_q.pop_front();
          compare_field("scl_drive", ByteW'(want.scl), ByteW'(seen.scl));
          compare_field("sda_drive", ByteW'(want.sda), ByteW'(seen.sda));
          compare_field("busy_res", ByteW'(want.busy), ByteW'(seen.busy));
          compare_field("done_res", ByteW'(want.done), ByteW'(seen.done));
          compare_field("read_byte", want.rx, seen.rx);
          compare_field("ack_seen", ByteW'(want.ack), ByteW'(seen.ack));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        wait_ticks = cfg_i.wait_ticks;
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_bus_tick(cmd_i.op, cmd_i.write_byte, cmd_i.send_ack, cmd_i.scl_in,
                         cmd_i.sda_in, want);
        expected_pins_q.push_back(want);
      end
      backlog = expected_pins_q.size();
    end
  end

endmodule

>>> dv/tb_i2c_bit_level_master.sv
// Testbench top of the I2C bit-level master: stimulus, flow control and final verdict.
`timescale 1ns / 100ps

module tb_i2c_bit_level_master;
  import i2cm_pkg::*;

  typedef enum int unsigned {
    SdaRandom,
    SdaHigh,
    SdaLow
  } sda_pattern_e;

  localparam logic [OpW-1:0] OpCodeMax = '1;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         model_busy;
  int unsigned  error_count;
  int unsigned  backlog;

  int unsigned  burst_left;
  bit           gaps_on;
  int unsigned  stretch_pct;
  int unsigned  noise_pct;
  sda_pattern_e sda_mode;
  int unsigned  cmd_count;

  i2cm_cfg_if cfg_bus ();
  i2cm_cmd_if cmd_bus ();
  i2cm_res_if res_bus ();

  i2c_bit_level_master dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  i2cm_checker #(
    .DelayBits (DelayBitsDef)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_bus),
    .cmd_i         (cmd_bus),
    .res_i         (res_bus),
    .bus_busy_o    (model_busy),
    .error_count_o (error_count),
    .backlog_o     (backlog)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("tb_i2c_bit_level_master failed");
    $finish;
  end

  // The result sink follows a random stall mask that is redrawn whenever its hold count runs out.
  initial begin
    logic [15:0] stall_mask;
    int unsigned hold;
    res_bus.ready = 1'b0;
    stall_mask = '1;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        hold = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom);
          default: stall_mask = 16'($urandom) | 16'($urandom);
        endcase
      end
      hold--;
      res_bus.ready <= stall_mask[hold % 16];
    end
  end

  function automatic logic [OpW-1:0] pick_noise_op();
    if ($urandom_range(0, 99) < noise_pct) begin
      return OpW'($urandom_range(OpStart, OpCodeMax));
    end
    return OpNone;
  endfunction

  task automatic send_tick(input logic [OpW-1:0] op, input logic [ByteW-1:0] wbyte,
                           input logic sack);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    cmd_bus.valid      <= 1'b1;
    cmd_bus.op         <= op;
    cmd_bus.write_byte <= wbyte;
    cmd_bus.send_ack   <= sack;
    cmd_bus.scl_in     <= ($urandom_range(0, 99) >= stretch_pct);
    case (sda_mode)
      SdaHigh: cmd_bus.sda_in <= 1'b1;
      SdaLow: cmd_bus.sda_in <= 1'b0;
      default: cmd_bus.sda_in <= 1'($urandom_range(0, 1));
    endcase
    do @(posedge clk_i); while (!cmd_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic issue_command(input op_e op, input logic [ByteW-1:0] wbyte,
                               input logic sack);
    while (model_busy) begin
      send_tick(OpNone, '0, 1'b0);
    end
    if ($urandom_range(0, 4) == 0) begin
      send_tick($urandom_range(0, 1) ? OpNone : OpW'($urandom_range(OpRead + 1, OpCodeMax)),
                8'($urandom), 1'($urandom));
    end
    send_tick(op, wbyte, sack);
    cmd_count++;
    while (model_busy) begin
      send_tick(pick_noise_op(), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic settle_bus();
    while (model_busy) begin
      send_tick(OpNone, '0, 1'b0);
    end
    cmd_bus.valid <= 1'b0;
    while (backlog != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_wait_ticks(input logic [WaitW-1:0] ticks);
    settle_bus();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.wait_ticks <= ticks;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random_transfer();
    int unsigned nbytes;
    logic        reading;
    logic        sack;
    if ($urandom_range(0, 9) == 0) begin
      issue_command(op_e'($urandom_range(OpStart, OpRead)), 8'($urandom), 1'($urandom));
      return;
    end
    issue_command(OpStart, 8'($urandom), 1'b0);
    reading = 1'($urandom_range(0, 1));
    issue_command(OpWrite, {7'($urandom), reading}, 1'b0);
    nbytes = $urandom_range(0, 4);
    for (int i = 0; i < nbytes; i++) begin
      if (reading) begin
        sack = (i + 1 != nbytes) ^ ($urandom_range(0, 9) == 0);
        issue_command(OpRead, 8'($urandom), sack);
      end else begin
        issue_command(OpWrite, 8'($urandom), 1'b0);
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      issue_command(OpStop, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_random_phase(input logic [WaitW-1:0] ticks, input int unsigned n_cmds);
    int unsigned target;
    write_wait_ticks(ticks);
    gaps_on     = ($urandom_range(0, 3) != 0);
    stretch_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
    noise_pct   = $urandom_range(0, 30);
    sda_mode    = SdaRandom;
    target      = cmd_count + n_cmds;
    while (cmd_count < target) begin
      run_random_transfer();
    end
  endtask

  initial begin
    cmd_bus.valid      = 1'b0;
    cmd_bus.op         = OpNone;
    cmd_bus.write_byte = '0;
    cmd_bus.send_ack   = 1'b0;
    cmd_bus.scl_in     = 1'b1;
    cmd_bus.sda_in     = 1'b1;
    cfg_bus.valid      = 1'b0;
    cfg_bus.wait_ticks = '0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    stretch_pct = 0;
    noise_pct   = 0;
    sda_mode    = SdaRandom;
    cmd_count   = 0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset value of the wait register.
    send_tick(OpW'(OpRead + 1), 8'hFF, 1'b1);
    send_tick(OpCodeMax, 8'h00, 1'b0);
    issue_command(OpStart, 8'h00, 1'b0);
    sda_mode = SdaLow;
    issue_command(OpWrite, 8'h00, 1'b0);
    sda_mode = SdaHigh;
    issue_command(OpWrite, 8'hFF, 1'b0);
    issue_command(OpRead, 8'h00, 1'b1);
    sda_mode = SdaLow;
    issue_command(OpRead, 8'hFF, 1'b0);
    sda_mode = SdaRandom;
    issue_command(OpWrite, 8'hA5, 1'b1);
    stretch_pct = 70;
    issue_command(OpRead, 8'h5A, 1'b1);
    stretch_pct = 0;
    noise_pct = 100;
    issue_command(OpWrite, 8'h5A, 1'b0);
    issue_command(OpRead, 8'hC3, 1'b0);
    noise_pct = 0;
    issue_command(OpStop, 8'h00, 1'b0);
    issue_command(OpStop, 8'hFF, 1'b1);
    issue_command(OpStart, 8'h00, 1'b0);

    write_wait_ticks('0);
    issue_command(OpStart, 8'h00, 1'b0);
    issue_command(OpWrite, 8'($urandom), 1'b0);
    issue_command(OpRead, 8'h00, 1'b1);
    issue_command(OpStop, 8'h00, 1'b0);

    write_wait_ticks(WaitW'(5));
    issue_command(OpStart, 8'h00, 1'b0);
    issue_command(OpStop, 8'h00, 1'b0);

    run_random_phase(WaitW'(1), 5);

    settle_bus();
    repeat (10) @(negedge clk_i);
    if (error_count == 0 && backlog == 0) begin
      $display("tb_i2c_bit_level_master passed");
    end else begin
      $display("tb_i2c_bit_level_master failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2c_bit_level_master.sv
hw/rtl/i2cm_checker.sv
dv/i2cm_checker.sv
dv/tb_i2c_bit_level_master.sv
